// ===== rtl/signed_integer_to_radix_text_macros.svh =====
// Assertion macros shared by the radix text converter RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SIRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SIRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sirt_pkg.sv =====
// Package for the radix text converter: widths, character codes,
// register indexes, sequencer states and the divider result struct.
// No dependencies.
`default_nettype none

package sirt_pkg;

  localparam int MAX_SYMBOLS   = 32;
  localparam int SYM_W         = 8;
  localparam int SYMS_PER_WORD = 8;
  localparam int ALPHA_WORDS   = MAX_SYMBOLS / SYMS_PER_WORD;
  localparam int WORD_W        = SYM_W * SYMS_PER_WORD;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 6;
  localparam int DIGIT_W       = $clog2(MAX_SYMBOLS);
  localparam int MAX_DIGITS    = VALUE_W;
  localparam int DIDX_W        = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W     = $clog2(VALUE_W);
  localparam int CFG_IDX_W     = 3;

  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYMBOL_COUNT = 3'd0,
    CFG_ALPHABET_0   = 3'd1,
    CFG_ALPHABET_1   = 3'd2,
    CFG_ALPHABET_2   = 3'd3,
    CFG_ALPHABET_3   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SIGN,
    S_DIGIT
  } state_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/sirt_div.sv =====
// Bit-serial restoring divider: 32-bit dividend by a radix of up to 32.
// One quotient bit per cycle, done pulses once all 32 quotient bits are in. Uses sirt_pkg.
`default_nettype none

module sirt_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [sirt_pkg::VALUE_W-1:0] dividend,
  input  wire logic [sirt_pkg::COUNT_W-1:0] divisor,
  output sirt_pkg::div_res_t                res
);
  import sirt_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0]   quot_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [COUNT_W-1:0]   trial;
  logic [COUNT_W-1:0]   diff;
  logic                 ge;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_r, quot_r[VALUE_W-1]};
    ge    = (trial >= divisor);
    diff  = trial - divisor;
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
    end else if (busy_r) begin
      quot_r <= {quot_r[VALUE_W-2:0], ge};
      rem_r  <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/signed_integer_to_radix_text.sv =====
// Radix text converter top level: config registers, alphabet check,
// digit sequencer and output register. Uses sirt_pkg, sirt_div and the
// assertion macros header.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tdata[31:0] value
//  out_    | out | out_tvalid / out_tready| tdata[7:0] char_code, tlast is_last
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// One item at a time: the alphabet check steps through its symbols, then the
// shared serial divider runs once per digit, then one cycle per
// character when out_tready stays high. The longest item is binary with the
// most negative value: accept, check, 32 digits, sign and 32 characters.
// The divider yields one quotient bit per cycle.
// rst_n clears the config registers to zero (radix 0, alphabet rejected).
// A stalled out_tready holds the sequencer; cfg_ready is always high.
`default_nettype none
`include "signed_integer_to_radix_text_macros.svh"

module signed_integer_to_radix_text (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: [31:0] value
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [31:0]                    in_tdata,
  // out_tdata: [7:0] char_code; is_last travels on out_tlast
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sirt_pkg::WORD_W-1:0]    cfg_data
);
  import sirt_pkg::*;

  // Configuration
  logic [COUNT_W-1:0] symbol_count_r;
  logic [WORD_W-1:0]  alpha_r [ALPHA_WORDS];
  logic [SYM_W-1:0]   sym_tab [MAX_SYMBOLS];
  logic [COUNT_W-1:0] n_eff;

  // Sequencer
  state_t             state_r, state_nxt;
  logic               neg_r;
  logic [VALUE_W-1:0] mag_r;
  logic [DIGIT_W-1:0] idx_r;
  logic [DIDX_W-1:0]  wr_idx_r;
  logic [DIDX_W-1:0]  rd_idx_r;
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];

  // Output register
  logic               out_valid_r;
  logic [SYM_W-1:0]   out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic               load_out;
  logic               out_free;

  // Shared lookup and check
  logic [DIGIT_W-1:0] cur_digit;
  logic [DIGIT_W-1:0] sym_addr;
  logic [SYM_W-1:0]   sym;
  logic               dup;
  logic               bad_sym;
  logic               div_start;
  div_res_t           div_res;
  logic [VALUE_W-1:0] in_value;
  logic               in_neg;

  // Write registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= '0;
      for (int w = 0; w < ALPHA_WORDS; w++) begin
        alpha_r[w] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYMBOL_COUNT: symbol_count_r <= cfg_data[COUNT_W-1:0];
        CFG_ALPHABET_0:   alpha_r[0] <= cfg_data;
        CFG_ALPHABET_1:   alpha_r[1] <= cfg_data;
        CFG_ALPHABET_2:   alpha_r[2] <= cfg_data;
        CFG_ALPHABET_3:   alpha_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slice the alphabet words into symbols
  for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_sym
    assign sym_tab[k] = alpha_r[k / SYMS_PER_WORD][(k % SYMS_PER_WORD) * SYM_W +: SYM_W];
  end

  // Cap the radix at the table size
  assign n_eff = (symbol_count_r > COUNT_W'(MAX_SYMBOLS)) ? COUNT_W'(MAX_SYMBOLS)
                                                          : symbol_count_r;

  // One symbol lookup, shared between the check and the digit output
  assign cur_digit = digits_r[rd_idx_r];
  assign sym_addr  = (state_r == S_CHECK) ? idx_r : cur_digit;
  assign sym       = sym_tab[sym_addr];

  // Compare the current symbol against every later symbol in range; NUL, minus and plus are also bad
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((COUNT_W'(j) > COUNT_W'(idx_r)) && (COUNT_W'(j) < n_eff) && (sym_tab[j] == sym)) begin
        dup = 1'b1;
      end
    end
    bad_sym = dup || (sym == CH_NUL) || (sym == CH_MINUS) || (sym == CH_PLUS);
  end

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_neg   = in_value[VALUE_W-1];

  sirt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (n_eff),
    .res      (div_res)
  );

  assign out_free = !out_valid_r || out_tready;

  // Next state and control
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    div_start    = 1'b0;
    load_out     = 1'b0;
    out_char_nxt = sym;
    out_last_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (n_eff < COUNT_W'(2)) ? S_IDLE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_sym) begin
          state_nxt = S_IDLE;
        end else if (COUNT_W'(idx_r) == n_eff - 1'b1) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_res.done) begin
          if ((div_res.quot != '0) && (wr_idx_r != DIDX_W'(MAX_DIGITS - 1))) begin
            state_nxt = S_DIV_GO;
          end else begin
            state_nxt = neg_r ? S_SIGN : S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_char_nxt = CH_MINUS;
          state_nxt    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_last_nxt = (rd_idx_r == '0);
          if (rd_idx_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer datapath: magnitude, indexes, digit store
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          neg_r    <= in_neg;
          mag_r    <= in_neg ? (VALUE_W'(0) - in_value) : in_value;
          idx_r    <= '0;
          wr_idx_r <= '0;
        end
      end
      S_CHECK: begin
        idx_r <= idx_r + 1'b1;
      end
      S_DIV_WAIT: begin
        if (div_res.done) begin
          mag_r              <= div_res.quot;
          digits_r[wr_idx_r] <= div_res.rem;
          rd_idx_r           <= wr_idx_r;
          wr_idx_r           <= wr_idx_r + 1'b1;
        end
      end
      S_DIGIT: begin
        if (out_free && (rd_idx_r != '0)) begin
          rd_idx_r <= rd_idx_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold until taken, refill from the sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // Divider completes only while the sequencer waits for it
  `SIRT_ASSERT_IMP(a_div_done_in_wait, div_res.done, state_r == S_DIV_WAIT,
    "divider finished outside the wait state")
  // A remainder is always a valid digit of the radix
  `SIRT_ASSERT_IMP(a_rem_in_range, div_res.done, COUNT_W'(div_res.rem) < n_eff,
    "remainder not below the radix")
  // Stored digits read back for output stay below the radix
  `SIRT_ASSERT_IMP(a_digit_in_range, state_r == S_DIGIT, COUNT_W'(cur_digit) < n_eff,
    "digit out of range at output")
  // A radix below two is rejected straight away
  `SIRT_ASSERT_NXT(a_short_reject, (state_r == S_IDLE) && in_tvalid && (n_eff < COUNT_W'(2)),
    state_r == S_IDLE, "short alphabet not rejected")

endmodule

`default_nettype wire
